[rtl/sdpg_pkg.sv]
`timescale 1ns / 1ps

package sdpg_pkg;

  localparam int unsigned TICK_HZ = 1000000;

  localparam int CMD_W   = 2;
  localparam int SPEED_W = 20;
  localparam int STEPS_W = 32;
  localparam int HALF_W  = 19;

  localparam logic [HALF_W-1:0] HALF_MAX = '1;

  // divider: constant dividend TICK_HZ, divisor 2*speed
  localparam int DIV_W = $clog2(TICK_HZ + 1);
  localparam int DVS_W = SPEED_W + 1;
  localparam int CNT_W = $clog2(DIV_W);

  localparam logic [DIV_W-1:0] TICK_VEC = DIV_W'(TICK_HZ);

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK = 2'd0,
    CMD_MOVE = 2'd1,
    CMD_STOP = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic               move_direction;
    logic [SPEED_W-1:0] move_speed_hz;
    logic [STEPS_W-1:0] move_steps;
  } in_t;

  typedef struct packed {
    logic               step_level;
    logic               dir_level;
    logic               moving;
    logic               move_done;
    logic [STEPS_W-1:0] steps_left;
  } out_t;

  typedef struct packed {
    logic item_go;     // apply tick / stop / unknown command from the input
    logic move_start;  // capture move fields, start divider
    logic div_step;    // one quotient bit
    logic move_load;   // arm the move with the computed half period
    logic out_load;    // load result register
  } ctl_t;

  typedef struct packed {
    logic div_last;
  } sts_t;

endpackage

[rtl/sdpg_div.sv]
`timescale 1ns / 1ps

module sdpg_div import sdpg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             step,
  input  logic [DVS_W-1:0] divisor,
  output logic [DIV_W-1:0] quotient,
  output logic             last
);

  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [DVS_W:0] rem_sh;
  logic [DVS_W:0] diff;
  logic           ge;

  // restoring division, dividend bits fed MSB first from the constant
  assign rem_sh = {rem_r, TICK_VEC[cnt_r]};
  assign ge     = rem_sh >= {1'b0, dvs_r};
  assign diff   = rem_sh - {1'b0, dvs_r};

  always_comb begin
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    if (start) begin
      rem_nxt = '0;
      dvs_nxt = divisor;
      quo_nxt = '0;
      cnt_nxt = CNT_W'(DIV_W - 1);
    end else if (step) begin
      rem_nxt = ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign quotient = quo_r;
  assign last     = (cnt_r == '0);

endmodule

[rtl/sdpg_datapath.sv]
`timescale 1ns / 1ps

module sdpg_datapath import sdpg_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  ctl_t ctl,
  input  in_t  in_data,
  output sts_t sts,
  output out_t out_data
);

  logic [HALF_W-1:0]  half_r, half_nxt;
  logic [HALF_W-1:0]  cdown_r, cdown_nxt;
  logic [STEPS_W-1:0] pulses_r, pulses_nxt;
  logic               step_r, step_nxt;
  logic               dir_r, dir_nxt;
  logic               active_r, active_nxt;
  logic               mv_dir_r, mv_dir_nxt;
  logic [STEPS_W-1:0] mv_steps_r, mv_steps_nxt;
  out_t               out_data_r, out_data_nxt;
  logic               done;

  logic [SPEED_W-1:0] speed_nz;
  logic [DIV_W-1:0]   quotient;
  logic [HALF_W-1:0]  half_calc;
  logic               div_last;

  assign speed_nz = (in_data.move_speed_hz == '0) ? SPEED_W'(1) : in_data.move_speed_hz;

  sdpg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctl.move_start),
    .step     (ctl.div_step),
    .divisor  ({speed_nz, 1'b0}),
    .quotient (quotient),
    .last     (div_last)
  );

  assign sts.div_last = div_last;

  // clamp half period to [1, HALF_MAX]
  always_comb begin
    if (quotient == '0) begin
      half_calc = HALF_W'(1);
    end else if (32'(quotient) > 32'(HALF_MAX)) begin
      half_calc = HALF_MAX;
    end else begin
      half_calc = HALF_W'(quotient);
    end
  end

  always_comb begin
    half_nxt     = half_r;
    cdown_nxt    = cdown_r;
    pulses_nxt   = pulses_r;
    step_nxt     = step_r;
    dir_nxt      = dir_r;
    active_nxt   = active_r;
    mv_dir_nxt   = mv_dir_r;
    mv_steps_nxt = mv_steps_r;
    done         = 1'b0;

    if (ctl.item_go) begin
      case (in_data.command)
        CMD_TICK: begin
          if (active_r) begin
            if (cdown_r > HALF_W'(1)) begin
              cdown_nxt = cdown_r - 1'b1;
            end else if (pulses_r == '0) begin
              step_nxt   = 1'b0;
              active_nxt = 1'b0;
              cdown_nxt  = '0;
              done       = 1'b1;
            end else begin
              step_nxt  = ~step_r;
              // rising edge uses up one step
              if (!step_r) begin
                pulses_nxt = pulses_r - 1'b1;
              end
              cdown_nxt = half_r;
            end
          end
        end
        CMD_STOP: begin
          step_nxt   = 1'b0;
          pulses_nxt = '0;
          cdown_nxt  = '0;
          active_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end

    if (ctl.move_start) begin
      mv_dir_nxt   = in_data.move_direction;
      mv_steps_nxt = in_data.move_steps;
    end

    if (ctl.move_load) begin
      dir_nxt    = mv_dir_r;
      half_nxt   = half_calc;
      pulses_nxt = mv_steps_r;
      step_nxt   = 1'b0;
      cdown_nxt  = half_calc;
      active_nxt = 1'b1;
    end

    out_data_nxt            = out_data_r;
    if (ctl.out_load) begin
      out_data_nxt.step_level = step_nxt;
      out_data_nxt.dir_level  = dir_nxt;
      out_data_nxt.moving     = active_nxt;
      out_data_nxt.move_done  = done;
      out_data_nxt.steps_left = pulses_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mv_dir_r   <= mv_dir_nxt;
    mv_steps_r <= mv_steps_nxt;
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      half_r   <= '0;
      cdown_r  <= '0;
      pulses_r <= '0;
      step_r   <= 1'b0;
      dir_r    <= 1'b0;
      active_r <= 1'b0;
    end else begin
      half_r   <= half_nxt;
      cdown_r  <= cdown_nxt;
      pulses_r <= pulses_nxt;
      step_r   <= step_nxt;
      dir_r    <= dir_nxt;
      active_r <= active_nxt;
    end
  end

  assign out_data = out_data_r;

endmodule

[rtl/sdpg_ctrl.sv]
`timescale 1ns / 1ps

module sdpg_ctrl import sdpg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] in_cmd,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  sts_t             sts,
  output ctl_t             ctl
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // result register can take a new value this cycle
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && out_free && in_cmd == CMD_MOVE) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.div_last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = out_free;
        if (in_valid && out_free) begin
          if (in_cmd == CMD_MOVE) begin
            ctl.move_start = 1'b1;
          end else begin
            ctl.item_go  = 1'b1;
            ctl.out_load = 1'b1;
          end
        end
      end
      ST_DIV: begin
        ctl.div_step = 1'b1;
      end
      ST_FINISH: begin
        if (out_free) begin
          ctl.move_load = 1'b1;
          ctl.out_load  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_nxt = ctl.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[rtl/step_dir_pulse_generator_top.sv]
// Channel   Direction  Handshake             Payload
// in_       input      in_valid / in_ready   in_data   (in_t)
// out_      output     out_valid / out_ready out_data  (out_t)
//
// Tick, stop and unknown commands may follow back to back;
// each is loaded into the output register at its own transfer edge.
// A move's half period comes from a bit-serial restoring divider that produces one
// quotient bit per cycle; the move result is loaded once the division is done and
// the output register is free.
// in_ready stays low from a move transfer until its result is loaded, and whenever
// the output register is full and out_ready is low. Reset is synchronous, active low;
// the step and direction state starts low.
`timescale 1ns / 1ps

module step_dir_pulse_generator_top import sdpg_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  ctl_t ctl;
  sts_t sts;

  sdpg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_data.command),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  sdpg_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .in_data  (in_data),
    .sts      (sts),
    .out_data (out_data)
  );

`ifndef NO_ASSERTIONS
  // a natural end leaves STEP low and the timer disarmed
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.move_done) |-> (!out_data.moving && !out_data.step_level))
    else $error("move_done with timer still armed or STEP high");

  // no steps can be pending once the timer is disarmed
  a_idle_no_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.moving) |-> (out_data.steps_left == '0))
    else $error("steps_left nonzero while not moving");

  // a move transfer blocks the input while the divider runs
  a_move_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.command == CMD_MOVE) |=> !in_ready)
    else $error("input ready right after a move transfer");
`endif

endmodule

[verif/step_dir_pulse_checker.sv]
`timescale 1ns / 1ps

module step_dir_pulse_checker import sdpg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_t         in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_t        out_data,
  output int unsigned mismatch_cnt,
  output int unsigned pins_pending
);

  // motor state as the block should hold it
  logic [HALF_W-1:0]  half_len;
  logic [HALF_W-1:0]  countdown;
  logic [STEPS_W-1:0] edges_left;
  logic               step_q;
  logic               dir_q;
  logic               armed;

  out_t pin_expect_q[$];

  function automatic logic [HALF_W-1:0] half_ticks(input logic [SPEED_W-1:0] spd);
    longint unsigned rate;
    longint unsigned q;
    rate = (spd == '0) ? 64'd1 : 64'(spd);
    q = 64'(TICK_HZ) / (2 * rate);
    if (q < 1) q = 1;
    if (q > 64'(HALF_MAX)) q = 64'(HALF_MAX);
    return q[HALF_W-1:0];
  endfunction

  task automatic advance_motor(input in_t it, output out_t res);
    logic finished;
    finished = 1'b0;
    case (it.command)
      CMD_TICK: begin
        if (armed) begin
          if (countdown > 1) begin
            countdown = countdown - 1'b1;
          end else if (edges_left == '0) begin
            step_q    = 1'b0;
            armed     = 1'b0;
            countdown = '0;
            finished  = 1'b1;
          end else begin
            step_q = ~step_q;
            if (step_q) edges_left = edges_left - 1'b1;
            countdown = half_len;
          end
        end
      end
      CMD_MOVE: begin
        dir_q      = it.move_direction;
        half_len   = half_ticks(it.move_speed_hz);
        edges_left = it.move_steps;
        step_q     = 1'b0;
        countdown  = half_len;
        armed      = 1'b1;
      end
      CMD_STOP: begin
        step_q     = 1'b0;
        edges_left = '0;
        countdown  = '0;
        armed      = 1'b0;
      end
      default: ;  // undefined command: no state change
    endcase
    res.step_level = step_q;
    res.dir_level  = dir_q;
    res.moving     = armed;
    res.move_done  = finished;
    res.steps_left = edges_left;
  endtask

  task automatic report(input string field, input longint unsigned want,
                        input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    out_t nxt;
    if (!rst_n) begin
      half_len     = '0;
      countdown    = '0;
      edges_left   = '0;
      step_q       = 1'b0;
      dir_q        = 1'b0;
      armed        = 1'b0;
      mismatch_cnt = 0;
      pin_expect_q.delete();
    end else begin
      // result transfer first: it always belongs to an older input transfer
      if (out_valid && out_ready) begin
        if (pin_expect_q.size() == 0) begin
          $display("%0t: unexpected result expected none actual %0h", $time, out_data);
          mismatch_cnt++;
        end else begin
          want = pin_expect_q.pop_front();
          report("step_level", want.step_level, out_data.step_level);
          report("dir_level",  want.dir_level,  out_data.dir_level);
          report("moving",     want.moving,     out_data.moving);
          report("move_done",  want.move_done,  out_data.move_done);
          report("steps_left", want.steps_left, out_data.steps_left);
        end
      end
      if (in_valid && in_ready) begin
        advance_motor(in_data, nxt);
        pin_expect_q.push_back(nxt);
      end
    end
    pins_pending <= pin_expect_q.size();
  end

endmodule

[verif/step_dir_pulse_generator_top_test.sv]
`timescale 1ns / 1ps

module step_dir_pulse_generator_top_test;
  import sdpg_pkg::*;

  localparam logic [CMD_W-1:0] CMD_JUNK = 2'd3;  // not decoded by the block
  localparam int ITEM_GOAL  = 550;
  localparam int CYCLE_CAP  = 400000;
  localparam int DRAIN_WAIT = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  int unsigned mismatch_cnt;
  int unsigned pins_pending;
  int items_sent = 0;

  step_dir_pulse_generator_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  step_dir_pulse_checker u_pin_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .mismatch_cnt (mismatch_cnt),
    .pins_pending (pins_pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_CAP) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // receiver: random stalls, one long hold-off to back up the block, one steady window
  initial begin
    int rcv_cyc;
    rcv_cyc = 0;
    forever begin
      @(posedge clk);
      rcv_cyc++;
      if (rcv_cyc >= 600 && rcv_cyc < 800) out_ready <= 1'b0;
      else if (rcv_cyc >= 1500 && rcv_cyc < 2100) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(99) >= 31);
    end
  end

  // called right after a rising edge; returns right after the transfer edge
  task automatic send(input logic [CMD_W-1:0] cmd, input logic dir,
                      input logic [SPEED_W-1:0] spd, input logic [STEPS_W-1:0] stp);
    in_t it;
    it.command        = cmd;
    it.move_direction = dir;
    it.move_speed_hz  = spd;
    it.move_steps     = stp;
    while (!(items_sent >= 250 && items_sent < 350) && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_ticks(input int n);
    repeat (n) begin
      if ($urandom_range(99) < 4)
        send(CMD_JUNK, 1'($urandom), SPEED_W'($urandom), $urandom);
      send(CMD_TICK, 1'($urandom), SPEED_W'($urandom), $urandom);
    end
  endtask

  task automatic send_stop();
    send(CMD_STOP, 1'($urandom), SPEED_W'($urandom), $urandom);
  endtask

  initial begin
    int pick;
    int nsteps;
    int half_est;
    int run;
    logic [SPEED_W-1:0] spd;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle tick and junk, fastest move, slowest move overridden by
    // a zero-step move, all-ones fields, stop mid-move, plain stop
    send(CMD_TICK, 1'b0, '0, '0);
    send(CMD_JUNK, 1'b1, '1, '1);
    send(CMD_MOVE, 1'b1, 20'd1000000, 32'd1);
    send(CMD_TICK, 1'b0, '0, '0);
    send(CMD_TICK, 1'b0, '0, '0);
    send(CMD_TICK, 1'b0, '0, '0);
    send(CMD_TICK, 1'b0, '0, '0);
    send(CMD_MOVE, 1'b0, '0, '0);
    send(CMD_TICK, 1'b0, '0, '0);
    send(CMD_MOVE, 1'b1, 20'd250000, '0);
    send(CMD_TICK, 1'b0, '0, '0);
    send(CMD_TICK, 1'b0, '0, '0);
    send(CMD_TICK, 1'b0, '0, '0);
    send(CMD_MOVE, 1'b1, '1, '1);
    send(CMD_TICK, 1'b1, '1, '1);
    send(CMD_TICK, 1'b1, '1, '1);
    send(CMD_JUNK, 1'b0, '0, '0);
    send(CMD_STOP, 1'b0, '0, '0);
    send(CMD_TICK, 1'b0, '0, '0);
    send(CMD_MOVE, 1'b0, 20'd333333, 32'd2);
    send(CMD_TICK, 1'b0, '0, '0);
    send(CMD_TICK, 1'b0, '0, '0);
    send(CMD_TICK, 1'b0, '0, '0);
    send(CMD_STOP, 1'b1, '1, '1);

    while (items_sent < ITEM_GOAL) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        // move with short half periods, mostly run to its end, sometimes cut short by a stop or a new move
        spd = ($urandom_range(3) == 0) ? SPEED_W'($urandom_range(50000, 125000))
                                       : SPEED_W'($urandom_range(125000, 1000000));
        nsteps   = $urandom_range(0, 5);
        half_est = TICK_HZ / (2 * int'(spd));
        if (half_est < 1) half_est = 1;
        run = (2 * nsteps + 1) * half_est + 1;
        send(CMD_MOVE, 1'($urandom), spd, STEPS_W'(nsteps));
        if ($urandom_range(9) == 0) begin
          send_ticks($urandom_range(1, run));
          if ($urandom_range(1)) send_stop();
          else send(CMD_MOVE, 1'($urandom), SPEED_W'($urandom_range(250000, 1000000)),
                    STEPS_W'($urandom_range(0, 2)));
        end else begin
          send_ticks(run + $urandom_range(0, 2));
        end
      end else if (pick < 85) begin
        // wide random fields, cut short by a stop
        send(CMD_MOVE, 1'($urandom), SPEED_W'($urandom), $urandom);
        send_ticks($urandom_range(0, 6));
        send_stop();
      end else if (pick < 95) begin
        case ($urandom_range(2))
          0: send_stop();
          1: send(CMD_JUNK, 1'($urandom), SPEED_W'($urandom), $urandom);
          default: send_ticks($urandom_range(1, 3));
        endcase
      end else begin
        // slow move replaced by another while still running
        send(CMD_MOVE, 1'($urandom), '0, $urandom);
        send_ticks($urandom_range(0, 3));
        send(CMD_MOVE, 1'($urandom), SPEED_W'($urandom_range(500000, 1000000)),
             STEPS_W'($urandom_range(0, 3)));
        send_ticks(10);
      end
    end

    in_valid <= 1'b0;
    // let the checker count the last transfer before looking at the backlog
    @(posedge clk);
    while (pins_pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_cnt == 0 && pins_pending == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[files.f]
rtl/sdpg_pkg.sv
rtl/sdpg_div.sv
rtl/sdpg_datapath.sv
rtl/sdpg_ctrl.sv
rtl/step_dir_pulse_generator_top.sv
verif/step_dir_pulse_checker.sv
verif/step_dir_pulse_generator_top_test.sv
